>>> rtl/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// Shared constants, codes and controller/datapath structs for the scoped
// chained hash table.
// ----------------------------------------------------------------------------
package sht_pkg;

  localparam int MAX_ENTRIES  = 256;
  localparam int HASH_BUCKETS = 64;
  localparam int MAX_SCOPES   = 16;
  localparam int MAX_FIELDS   = 1024;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 11;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;

  localparam int EIDX_W = $clog2(MAX_ENTRIES);
  localparam int ECNT_W = EIDX_W + 1;
  localparam int BKT_W  = $clog2(HASH_BUCKETS);
  localparam int SCP_W  = $clog2(MAX_SCOPES);
  localparam int SCNT_W = SCP_W + 1;
  localparam int FLD_W  = $clog2(MAX_FIELDS);
  localparam int FCNT_W = FLD_W + 1;
  localparam int SUM_W  = ((FCNT_W > SLOT_W) ? FCNT_W : SLOT_W) + 1;

  localparam logic [ECNT_W-1:0] NO_ENTRY = ECNT_W'(MAX_ENTRIES);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_PUSH   = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_ENTRIES_FULL = 3'd2,
    ST_FIELDS_FULL  = 3'd3,
    ST_SCOPES_FULL  = 3'd4,
    ST_NOT_TOP      = 3'd5,
    ST_SYSTEM       = 3'd6
  } status_t;

  typedef struct packed {
    logic ld_in;
    logic head_rd;
    logic ins_wr;
    logic find_start;
    logic find_next;
    logic find_hit;
    logic pop_step;
    logic pop_head_wr;
    logic pop_commit;
    logic push_commit;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ent_full;
    logic fld_full;
    logic scp_full;
    logic not_top;
    logic sys_scope;
    logic head_live;
    logic key_hit;
    logic link_live;
    logic pop_more;
  } flags_t;

endpackage

>>> rtl/sht_in_if.sv
// ----------------------------------------------------------------------------
// sht_in_if
// Request channel: operation and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sht_in_if;
  import sht_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key_hash;
  logic [SLOT_W-1:0] field_slots;
  logic [SCP_W-1:0]  scope_index;

  modport source (output valid, operation, key_hash, field_slots, scope_index,
                  input ready);
  modport sink (input valid, operation, key_hash, field_slots, scope_index,
                output ready);
endinterface

>>> rtl/sht_out_if.sv
// ----------------------------------------------------------------------------
// sht_out_if
// Response channel: status and result indexes, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sht_out_if;
  import sht_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [EIDX_W-1:0] entry_index;
  logic [FLD_W-1:0]  field_start;
  logic [SCP_W-1:0]  scope_out;

  modport source (output valid, status, entry_index, field_start, scope_out,
                  input ready);
  modport sink (input valid, status, entry_index, field_start, scope_out,
                output ready);
endinterface

>>> rtl/sht_dp.sv
// ----------------------------------------------------------------------------
// sht_dp
// Datapath: bucket heads, entry key/link memories, counters, scope marks
// and result registers.
// ----------------------------------------------------------------------------
module sht_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  sht_pkg::cmd_t              cmd,
  output sht_pkg::flags_t            flags,
  input  logic [sht_pkg::OP_W-1:0]   operation,
  input  logic [sht_pkg::KEY_W-1:0]  key_hash,
  input  logic [sht_pkg::SLOT_W-1:0] field_slots,
  input  logic [sht_pkg::SCP_W-1:0]  scope_index,
  output logic [sht_pkg::EIDX_W-1:0] entry_index,
  output logic [sht_pkg::FLD_W-1:0]  field_start,
  output logic [sht_pkg::SCP_W-1:0]  scope_out
);
  import sht_pkg::*;

  op_t               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [SLOT_W-1:0] slots_q;
  logic [SCP_W-1:0]  sidx_q;

  logic [ECNT_W-1:0] head_mem [HASH_BUCKETS];
  logic [HASH_BUCKETS-1:0] head_vld;
  logic [ECNT_W-1:0] head_rd_q;
  logic              head_vld_q;
  logic [ECNT_W-1:0] head_val;

  logic [KEY_W-1:0]  key_mem  [MAX_ENTRIES];
  logic [ECNT_W-1:0] link_mem [MAX_ENTRIES];
  logic [KEY_W-1:0]  ek_q;
  logic [ECNT_W-1:0] el_q;

  logic [ECNT_W-1:0] entry_count;
  logic [FCNT_W-1:0] slot_used;
  logic [SCNT_W-1:0] scope_count;
  logic [ECNT_W-1:0] sfe [MAX_SCOPES];
  logic [FCNT_W-1:0] sff [MAX_SCOPES];
  logic [ECNT_W-1:0] cur_idx;

  logic [EIDX_W-1:0] w_eidx;
  logic [FLD_W-1:0]  w_fstart;
  logic [SCP_W-1:0]  w_sout;

  logic [BKT_W-1:0]  bkt_in;
  logic [BKT_W-1:0]  head_waddr;
  logic [ECNT_W-1:0] head_wdata;
  logic              head_we;
  logic [ECNT_W-1:0] ent_raddr;
  logic              ent_re;
  logic [SUM_W-1:0]  fld_sum;
  logic [SCP_W-1:0]  push_idx;

  assign bkt_in   = key_q[BKT_W-1:0];
  assign head_val = head_vld_q ? head_rd_q : NO_ENTRY;
  assign push_idx = scope_count[SCP_W-1:0];

  assign head_we    = cmd.ins_wr | cmd.pop_head_wr;
  assign head_waddr = cmd.ins_wr ? bkt_in : ek_q[BKT_W-1:0];
  assign head_wdata = cmd.ins_wr ? entry_count : el_q;

  assign ent_re = cmd.find_start | cmd.find_next | cmd.pop_step;
  always_comb begin
    priority if (cmd.find_start) begin
      ent_raddr = head_val;
    end else if (cmd.find_next) begin
      ent_raddr = el_q;
    end else begin
      ent_raddr = entry_count - ECNT_W'(1);
    end
  end

  assign fld_sum = SUM_W'(slot_used) + SUM_W'(slots_q);

  assign flags.op        = op_q;
  assign flags.ent_full  = entry_count >= ECNT_W'(MAX_ENTRIES);
  assign flags.fld_full  = (slots_q != '0) && (fld_sum > SUM_W'(MAX_FIELDS));
  assign flags.scp_full  = scope_count >= SCNT_W'(MAX_SCOPES);
  assign flags.not_top   = (SCNT_W'(sidx_q) + SCNT_W'(1)) != scope_count;
  assign flags.sys_scope = sidx_q == '0;
  assign flags.head_live = head_val < entry_count;
  assign flags.key_hit   = ek_q == key_q;
  assign flags.link_live = el_q < entry_count;
  assign flags.pop_more  = entry_count > sfe[sidx_q];

  // bucket head memory
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (cmd.head_rd) begin
      head_rd_q <= head_mem[bkt_in];
    end
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      key_mem[entry_count[EIDX_W-1:0]]  <= key_q;
      link_mem[entry_count[EIDX_W-1:0]] <= head_val;
    end
    if (ent_re) begin
      ek_q <= key_mem[ent_raddr[EIDX_W-1:0]];
      el_q <= link_mem[ent_raddr[EIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld    <= '0;
      head_vld_q  <= 1'b0;
      entry_count <= '0;
      slot_used   <= '0;
      scope_count <= SCNT_W'(1);
      for (int i = 0; i < MAX_SCOPES; i++) begin
        sfe[i] <= '0;
        sff[i] <= '0;
      end
    end else begin
      if (cmd.head_rd) begin
        head_vld_q <= head_vld[bkt_in];
      end
      if (head_we) begin
        head_vld[head_waddr] <= 1'b1;
      end
      if (cmd.ins_wr) begin
        entry_count <= entry_count + ECNT_W'(1);
        if (slots_q != '0) begin
          slot_used <= slot_used + FCNT_W'(slots_q);
        end
      end
      if (cmd.pop_step) begin
        entry_count <= entry_count - ECNT_W'(1);
      end
      if (cmd.push_commit) begin
        sfe[push_idx] <= entry_count;
        sff[push_idx] <= slot_used;
        scope_count   <= scope_count + SCNT_W'(1);
      end
      if (cmd.pop_commit) begin
        if (sff[sidx_q] < slot_used) begin
          slot_used <= sff[sidx_q];
        end
        scope_count <= scope_count - SCNT_W'(1);
        sfe[sidx_q] <= '0;
        sff[sidx_q] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_q     <= op_t'(operation);
      key_q    <= key_hash;
      slots_q  <= field_slots;
      sidx_q   <= scope_index;
      w_eidx   <= '0;
      w_fstart <= '0;
      w_sout   <= '0;
    end
    if (cmd.ins_wr) begin
      w_eidx   <= entry_count[EIDX_W-1:0];
      w_fstart <= (slots_q != '0) ? slot_used[FLD_W-1:0] : '0;
    end
    if (cmd.find_start) begin
      cur_idx <= head_val;
    end
    if (cmd.find_next) begin
      cur_idx <= el_q;
    end
    if (cmd.find_hit) begin
      w_eidx <= cur_idx[EIDX_W-1:0];
    end
    if (cmd.push_commit) begin
      w_sout <= push_idx;
    end
    if (cmd.out_ld) begin
      entry_index <= w_eidx;
      field_start <= w_fstart;
      scope_out   <= w_sout;
    end
  end

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |=> entry_count == $past(entry_count) + ECNT_W'(1))
    else $error("entry count did not advance on insert");

  a_pop_scope: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_commit |=> scope_count == $past(scope_count) - SCNT_W'(1))
    else $error("scope count did not drop on pop");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_step |-> entry_count > sfe[sidx_q])
    else $error("pop unlinked below the scope mark");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    entry_count <= ECNT_W'(MAX_ENTRIES) && slot_used <= FCNT_W'(MAX_FIELDS)
    && scope_count != '0)
    else $error("table counters out of range");

endmodule

>>> rtl/sht_ctrl.sv
// ----------------------------------------------------------------------------
// sht_ctrl
// Controller: sequences insert, find chain walk, push and pop unlink walk,
// holds result status and response valid.
// ----------------------------------------------------------------------------
module sht_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sht_pkg::STAT_W-1:0] status,
  input  sht_pkg::flags_t            flags,
  output sht_pkg::cmd_t              cmd
);
  import sht_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DISPATCH  = 8'b0000_0010,
    S_INS_WR    = 8'b0000_0100,
    S_FIND_HEAD = 8'b0000_1000,
    S_FIND_CMP  = 8'b0001_0000,
    S_POP_CHK   = 8'b0010_0000,
    S_POP_WR    = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  state_t  state, state_next;
  status_t w_status, w_status_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    w_status_next = w_status;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in     = 1'b1;
          w_status_next = ST_OK;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (flags.op)
          OP_INSERT: begin
            priority if (flags.ent_full) begin
              w_status_next = ST_ENTRIES_FULL;
              state_next    = S_DONE;
            end else if (flags.fld_full) begin
              w_status_next = ST_FIELDS_FULL;
              state_next    = S_DONE;
            end else begin
              cmd.head_rd = 1'b1;
              state_next  = S_INS_WR;
            end
          end
          OP_FIND: begin
            cmd.head_rd = 1'b1;
            state_next  = S_FIND_HEAD;
          end
          OP_PUSH: begin
            if (flags.scp_full) begin
              w_status_next = ST_SCOPES_FULL;
            end else begin
              cmd.push_commit = 1'b1;
            end
            state_next = S_DONE;
          end
          OP_POP: begin
            priority if (flags.not_top) begin
              w_status_next = ST_NOT_TOP;
              state_next    = S_DONE;
            end else if (flags.sys_scope) begin
              w_status_next = ST_SYSTEM;
              state_next    = S_DONE;
            end else begin
              state_next = S_POP_CHK;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_next = S_DONE;
      end
      S_FIND_HEAD: begin
        if (flags.head_live) begin
          cmd.find_start = 1'b1;
          state_next     = S_FIND_CMP;
        end else begin
          w_status_next = ST_NOT_FOUND;
          state_next    = S_DONE;
        end
      end
      S_FIND_CMP: begin
        priority if (flags.key_hit) begin
          cmd.find_hit = 1'b1;
          state_next   = S_DONE;
        end else if (flags.link_live) begin
          cmd.find_next = 1'b1;
        end else begin
          w_status_next = ST_NOT_FOUND;
          state_next    = S_DONE;
        end
      end
      S_POP_CHK: begin
        if (flags.pop_more) begin
          cmd.pop_step = 1'b1;
          state_next   = S_POP_WR;
        end else begin
          cmd.pop_commit = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_POP_WR: begin
        cmd.pop_head_wr = 1'b1;
        state_next      = S_POP_CHK;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      w_status  <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      w_status <= w_status_next;
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      status <= w_status;
    end
  end

endmodule

>>> rtl/scoped_chained_hash_table_unit.sv
// ----------------------------------------------------------------------------
// scoped_chained_hash_table_unit
// Hash table of 32-bit keys on bucket chains, grouped into a scope stack.
// ----------------------------------------------------------------------------
// req carries one operation per transaction: insert, find, push scope or
// pop scope. rsp returns exactly one transaction per request with status,
// entry index, first field slot and pushed scope index.
// One request is in flight at a time; req.ready is high only while the
// controller is idle, and the next request is taken while a response waits.
// From request accept, every operation passes S_DISPATCH and ends in
// S_DONE. Push and any rejected operation go straight to S_DONE; insert
// passes S_INS_WR; find passes S_FIND_HEAD, then S_FIND_CMP once per chain
// entry visited; pop alternates S_POP_CHK and S_POP_WR per entry removed
// and ends in S_POP_CHK. A new request is taken only after the last one
// has loaded its response register.
// The find and pop walks read one entry per step from the key/link memory.
// Reset (rst, synchronous) leaves scope 0 open and no entries; bucket heads
// read empty through per-bucket valid bits, no clearing pass is needed.
// A stalled rsp holds its transaction; a finished request waits in the
// controller until the response register frees up.
// ----------------------------------------------------------------------------
module scoped_chained_hash_table_unit (
  input logic       clk,
  input logic       rst,
  sht_in_if.sink    req,
  sht_out_if.source rsp
);
  import sht_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  sht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .flags     (flags),
    .cmd       (cmd)
  );

  sht_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .flags       (flags),
    .operation   (req.operation),
    .key_hash    (req.key_hash),
    .field_slots (req.field_slots),
    .scope_index (req.scope_index),
    .entry_index (rsp.entry_index),
    .field_start (rsp.field_start),
    .scope_out   (rsp.scope_out)
  );

endmodule

>>> sim/tb_scoped_chained_hash_table_unit.sv
// ----------------------------------------------------------------------------
// tb_scoped_chained_hash_table_unit
// Drives insert, find, push and pop transactions with random idling on both
// channels and checks every response against a behavioral table model.
// ----------------------------------------------------------------------------
module tb_scoped_chained_hash_table_unit;
  import sht_pkg::*;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slots;
    logic [SCP_W-1:0]  sidx;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [EIDX_W-1:0] eidx;
    logic [FLD_W-1:0]  fstart;
    logic [SCP_W-1:0]  sout;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sht_in_if  req ();
  sht_out_if rsp ();

  scoped_chained_hash_table_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // table model
  int unsigned heads [HASH_BUCKETS];
  logic [KEY_W-1:0] keys [MAX_ENTRIES];
  int unsigned links [MAX_ENTRIES];
  int unsigned n_ent, n_fld, n_scp;
  int unsigned scp_ent [MAX_SCOPES];
  int unsigned scp_fld [MAX_SCOPES];

  req_t pending_q[$];
  rsp_t expected_q[$];
  logic [KEY_W-1:0] used_keys[$];

  int  errors = 0;
  int  cycles = 0;
  int  send_idle = 13;
  int  recv_idle = 59;
  int  hold_cnt = 0;
  bit  hold_off = 0;
  bit  hold_done = 0;
  bit  send_pause = 0;
  bit  req_taken = 0;

  function automatic int unsigned walk_find(logic [KEY_W-1:0] key);
    int unsigned idx;
    idx = heads[key % HASH_BUCKETS];
    for (int s = 0; s < MAX_ENTRIES && idx < n_ent; s++) begin
      if (keys[idx] == key) return idx;
      idx = links[idx];
    end
    return MAX_ENTRIES;
  endfunction

  function automatic void unlink(int unsigned v);
    int unsigned b, cur, prev;
    b = keys[v] % HASH_BUCKETS;
    cur = heads[b];
    prev = MAX_ENTRIES;
    for (int s = 0; s < MAX_ENTRIES && cur < n_ent && cur != v; s++) begin
      prev = cur;
      cur = links[cur];
    end
    if (cur != v) return;
    if (prev == MAX_ENTRIES) heads[b] = links[v];
    else links[prev] = links[v];
  endfunction

  function automatic rsp_t predict_table(req_t r);
    rsp_t o;
    int unsigned idx, first;
    o = '0;
    o.status = ST_OK;
    case (r.op)
      OP_INSERT: begin
        if (n_ent >= MAX_ENTRIES) o.status = ST_ENTRIES_FULL;
        else if (r.slots > 0 && n_fld + r.slots > MAX_FIELDS) o.status = ST_FIELDS_FULL;
        else begin
          idx = n_ent;
          keys[idx] = r.key;
          links[idx] = heads[r.key % HASH_BUCKETS];
          heads[r.key % HASH_BUCKETS] = idx;
          n_ent++;
          o.eidx = EIDX_W'(idx);
          if (r.slots > 0) begin
            o.fstart = FLD_W'(n_fld);
            n_fld += r.slots;
          end
        end
      end
      OP_FIND: begin
        idx = walk_find(r.key);
        if (idx == MAX_ENTRIES) o.status = ST_NOT_FOUND;
        else o.eidx = EIDX_W'(idx);
      end
      OP_PUSH: begin
        if (n_scp >= MAX_SCOPES) o.status = ST_SCOPES_FULL;
        else begin
          o.sout = SCP_W'(n_scp);
          scp_ent[n_scp] = n_ent;
          scp_fld[n_scp] = n_fld;
          n_scp++;
        end
      end
      default: begin
        if (r.sidx + 1 != n_scp) o.status = ST_NOT_TOP;
        else if (r.sidx == 0) o.status = ST_SYSTEM;
        else begin
          first = scp_ent[r.sidx];
          for (int unsigned i = first; i < n_ent; i++) unlink(i);
          if (first < n_ent) n_ent = first;
          if (scp_fld[r.sidx] < n_fld) n_fld = scp_fld[r.sidx];
          n_scp--;
          scp_ent[r.sidx] = 0;
          scp_fld[r.sidx] = 0;
        end
      end
    endcase
    return o;
  endfunction

  function automatic req_t mk(op_t op, logic [KEY_W-1:0] key, int slots, int sidx);
    req_t r;
    r.op = op;
    r.key = key;
    r.slots = SLOT_W'(slots);
    r.sidx = SCP_W'(sidx);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 7) * HASH_BUCKETS + 5;
    return $urandom;
  endfunction

  function automatic int pick_slots();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(0, 2047);
      2: return $urandom_range(100, 400);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic req_t random_req();
    int p;
    logic [KEY_W-1:0] k;
    p = $urandom_range(0, 99);
    if (p < 40) begin
      k = pick_key();
      used_keys.push_back(k);
      if (used_keys.size() > 64) void'(used_keys.pop_front());
      return mk(OP_INSERT, k, pick_slots(), $urandom_range(0, 15));
    end
    if (p < 70) return mk(OP_FIND, pick_key(), $urandom_range(0, 2047), $urandom_range(0, 15));
    if (p < 83) return mk(OP_PUSH, $urandom, $urandom_range(0, 2047), $urandom_range(0, 15));
    return mk(OP_POP, $urandom, $urandom_range(0, 2047), $urandom_range(0, 15));
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.operation <= '0;
      req.key_hash <= '0;
      req.field_slots <= '0;
      req.scope_index <= '0;
    end else if (!req.valid || req_taken) begin
      if (pending_q.size() > 0 && !send_pause && $urandom_range(0, 99) >= send_idle) begin
        req_t r;
        r = pending_q.pop_front();
        req.valid <= 1'b1;
        req.operation <= r.op;
        req.key_hash <= r.key;
        req.field_slots <= r.slots;
        req.scope_index <= r.sidx;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_off && !hold_done) begin
      rsp.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 299) hold_done <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    req_taken <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready)
      expected_q.push_back(predict_table(mk(op_t'(req.operation), req.key_hash,
                                            req.field_slots, req.scope_index)));
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response status=%0d", $time, rsp.status);
        errors++;
      end else begin
        rsp_t e;
        e = expected_q.pop_front();
        if (rsp.status !== e.status || rsp.entry_index !== e.eidx ||
            rsp.field_start !== e.fstart || rsp.scope_out !== e.sout) begin
          $display("%0t: mismatch expected st=%0d ent=%0d fld=%0d scp=%0d",
                   $time, e.status, e.eidx, e.fstart, e.sout);
          $display("%0t:          actual   st=%0d ent=%0d fld=%0d scp=%0d",
                   $time, rsp.status, rsp.entry_index, rsp.field_start, rsp.scope_out);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycles < 3000000) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || req.valid) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < HASH_BUCKETS; i++) heads[i] = MAX_ENTRIES;
    for (int i = 0; i < MAX_SCOPES; i++) begin
      scp_ent[i] = 0;
      scp_fld[i] = 0;
    end
    n_ent = 0;
    n_fld = 0;
    n_scp = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed
    pending_q.push_back(mk(OP_FIND, 32'h0, 0, 0));
    pending_q.push_back(mk(OP_POP, 32'h0, 0, 0));
    pending_q.push_back(mk(OP_POP, 32'h0, 0, 4'hF));
    pending_q.push_back(mk(OP_INSERT, 32'h0, 0, 0));
    pending_q.push_back(mk(OP_INSERT, 32'hFFFF_FFFF, 1, 4'hF));
    pending_q.push_back(mk(OP_INSERT, 32'h40, 11'h7FF, 0));
    pending_q.push_back(mk(OP_INSERT, 32'h40, 1023, 0));
    pending_q.push_back(mk(OP_INSERT, 32'h80, 1, 0));
    pending_q.push_back(mk(OP_FIND, 32'h0, 0, 0));
    pending_q.push_back(mk(OP_FIND, 32'h40, 0, 0));
    pending_q.push_back(mk(OP_FIND, 32'hFFFF_FFFF, 0, 0));
    pending_q.push_back(mk(OP_FIND, 32'h5555_AAAA, 0, 0));
    pending_q.push_back(mk(OP_PUSH, 32'h0, 0, 0));
    pending_q.push_back(mk(OP_INSERT, 32'h0, 0, 0));
    pending_q.push_back(mk(OP_FIND, 32'h0, 0, 0));
    pending_q.push_back(mk(OP_POP, 32'h0, 0, 0));
    pending_q.push_back(mk(OP_POP, 32'h0, 0, 1));
    pending_q.push_back(mk(OP_FIND, 32'h0, 0, 0));
    for (int i = 0; i < 16; i++) pending_q.push_back(mk(OP_PUSH, 32'h0, 0, 0));
    for (int i = 15; i >= 0; i--) pending_q.push_back(mk(OP_POP, 32'h0, 0, i));
    drain();

    // entries full: fill the table in a scope then pop it
    pending_q.push_back(mk(OP_PUSH, 32'h0, 0, 0));
    for (int i = 0; i < 260; i++) pending_q.push_back(mk(OP_INSERT, $urandom, 0, 0));
    pending_q.push_back(mk(OP_INSERT, $urandom, 1, 0));
    pending_q.push_back(mk(OP_FIND, 32'h40, 0, 0));
    pending_q.push_back(mk(OP_POP, 32'h0, 0, 1));
    // receiver holds off while the sender keeps offering
    hold_off = 1;
    wait (hold_done);
    hold_off = 0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 59;
        recv_idle = 13;
      end else if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int i = 0; i < 105; i++) begin
        if (($urandom_range(0, 40) == 0) && n_ent > 200) pending_q.push_back(mk(OP_POP, 0, 0, 1));
        pending_q.push_back(random_req());
      end
      repeat (200) @(posedge clk);
      // sender pauses until every outstanding response is back
      send_pause = 1;
      while (expected_q.size() > 0 || req.valid) @(posedge clk);
      send_pause = 0;
      for (int i = 0; i < 105; i++) begin
        if (($urandom_range(0, 40) == 0) && n_ent > 200) pending_q.push_back(mk(OP_POP, 0, 0, 1));
        pending_q.push_back(random_req());
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sht_pkg.sv
rtl/sht_in_if.sv
rtl/sht_out_if.sv
rtl/sht_dp.sv
rtl/sht_ctrl.sv
rtl/scoped_chained_hash_table_unit.sv
sim/tb_scoped_chained_hash_table_unit.sv
